[rtl/core/sorted_round_robin_scheduler_assert.svh]
// Assertion macros for the sorted round robin scheduler.
`ifndef SORTED_ROUND_ROBIN_SCHEDULER_ASSERT_SVH
`define SORTED_ROUND_ROBIN_SCHEDULER_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define SRRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define SRRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/srrs_pkg.sv]
// Types, constants and compare function of the sorted round robin scheduler.
`default_nettype none

package srrs_pkg;

    localparam int MAX_TASKS = 32;
    localparam int IDX_W     = $clog2(MAX_TASKS);
    localparam int CNT_W     = $clog2(MAX_TASKS + 1);

    localparam int ID_W    = 5;
    localparam int NID_W   = 6;
    localparam int PRIO_W  = 8;
    localparam int BURST_W = 16;
    localparam int MODE_W  = 2;

    localparam logic [BURST_W-1:0] QUANTUM_RESET = 16'd5;

    localparam logic [MODE_W-1:0] SORT_BURST = 2'd1;
    localparam logic [MODE_W-1:0] SORT_PRIO  = 2'd2;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_NEXT  = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic {
        CFG_SORT_MODE = 1'b0,
        CFG_QUANTUM   = 1'b1
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_KEY_RD,
        ST_KEY_LAT,
        ST_CMP,
        ST_PLACE,
        ST_FETCH,
        ST_SLICE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [PRIO_W-1:0]  prio;
        logic [BURST_W-1:0] remaining;
    } slot_t;

    function automatic logic goes_before(
        input logic [MODE_W-1:0] mode,
        input slot_t             a,
        input slot_t             b
    );
        logic res;
        res = 1'b0;
        if (mode == SORT_BURST)
        begin
            res = a.remaining < b.remaining;
        end
        else if (mode == SORT_PRIO)
        begin
            res = a.prio > b.prio;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

[rtl/core/sorted_round_robin_scheduler.sv]
// Sorted round robin scheduler: a task table ordered by one shared comparator
// under a sequencer and served in round robin slices. A load or a clear is taken
// in the idle state, which stays ready. A next request on a nonempty table passes
// through the fetch, slice and emit steps; it holds in the emit step while an
// earlier result still waits in the output register. When a task finishes, the
// entries behind it move down one at a time, each with a read and a write step.
// The first request after a load or a sort_mode write first reorders the table
// by insertion sort in burst or priority mode: a key read, a key latch and a
// compare step for each entry, and a further compare step for each entry moved.
// There is no clearing pass; the table needs none.
`default_nettype none

`include "sorted_round_robin_scheduler_assert.svh"

module sorted_round_robin_scheduler
    import srrs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,  // task_priority[7:0], task_burst[23:8]
    input  wire logic [1:0]  s_axis_tuser,  // opcode[1:0]
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [23:0]      m_axis_tdata,  // task_id[4:0], run_time[20:5],
                                            // task_finished[21], zero[23:22]
    output logic             m_axis_tuser,  // schedule_empty[0]
    input  wire logic        cfg_we,
    input  wire logic        cfg_addr,
    input  wire logic [15:0] cfg_wdata
);

    state_t             state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [NID_W-1:0]   nid_reg, nid_next;
    logic [IDX_W-1:0]   turn_reg, turn_next;
    logic               ordered_reg, ordered_next;
    logic [MODE_W-1:0]  mode_reg;
    logic [BURST_W-1:0] quantum_reg;

    logic [CNT_W-1:0]   i_reg, i_next;
    logic [IDX_W-1:0]   j_reg, j_next;
    logic [IDX_W-1:0]   pos_reg, pos_next;
    slot_t              key_reg, key_next;

    logic [ID_W-1:0]    res_id_reg, res_id_next;
    logic [BURST_W-1:0] res_run_reg, res_run_next;
    logic               res_fin_reg, res_fin_next;
    logic               res_empty_reg, res_empty_next;

    logic               m_valid_reg, m_valid_next;
    logic [23:0]        m_data_reg, m_data_next;
    logic               m_user_reg, m_user_next;

    slot_t              mem [MAX_TASKS];
    slot_t              rd_data_reg;
    logic [IDX_W-1:0]   rd_addr;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    slot_t              wr_data;

    logic               s_fire;
    logic [BURST_W-1:0] q_eff;
    logic [CNT_W-1:0]   i_inc;
    logic [CNT_W-1:0]   pos_inc;
    logic [CNT_W-1:0]   count_dec;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    assign q_eff     = (quantum_reg == '0) ? BURST_W'(1) : quantum_reg;
    assign i_inc     = i_reg + CNT_W'(1);
    assign pos_inc   = CNT_W'(pos_reg) + CNT_W'(1);
    assign count_dec = count_reg - CNT_W'(1);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            nid_reg     <= '0;
            turn_reg    <= '0;
            ordered_reg <= 1'b0;
            mode_reg    <= '0;
            quantum_reg <= QUANTUM_RESET;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            nid_reg     <= nid_next;
            turn_reg    <= turn_next;
            ordered_reg <= ordered_next;
            m_valid_reg <= m_valid_next;
            if (cfg_we && cfg_addr == CFG_SORT_MODE)
            begin
                mode_reg <= cfg_wdata[MODE_W-1:0];
            end
            if (cfg_we && cfg_addr == CFG_QUANTUM)
            begin
                quantum_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg         <= i_next;
        j_reg         <= j_next;
        pos_reg       <= pos_next;
        key_reg       <= key_next;
        res_id_reg    <= res_id_next;
        res_run_reg   <= res_run_next;
        res_fin_reg   <= res_fin_next;
        res_empty_reg <= res_empty_next;
        m_data_reg    <= m_data_next;
        m_user_reg    <= m_user_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        nid_next       = nid_reg;
        turn_next      = turn_reg;
        ordered_next   = ordered_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        pos_next       = pos_reg;
        key_next       = key_reg;
        res_id_next    = res_id_reg;
        res_run_next   = res_run_reg;
        res_fin_next   = res_fin_reg;
        res_empty_next = res_empty_reg;
        m_valid_next   = m_valid_reg && !m_axis_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        rd_addr        = '0;
        wr_en          = 1'b0;
        wr_addr        = '0;
        wr_data        = rd_data_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_fire)
                begin
                    case (s_axis_tuser)
                        OP_LOAD:
                        begin
                            if (count_reg < CNT_W'(MAX_TASKS))
                            begin
                                wr_en          = 1'b1;
                                wr_addr        = count_reg[IDX_W-1:0];
                                wr_data.id     = nid_reg[ID_W-1:0];
                                wr_data.prio   = s_axis_tdata[7:0];
                                wr_data.remaining = s_axis_tdata[23:8];
                                count_next     = count_reg + CNT_W'(1);
                                nid_next       = nid_reg + NID_W'(1);
                                ordered_next   = 1'b0;
                            end
                        end
                        OP_CLEAR:
                        begin
                            count_next   = '0;
                            nid_next     = '0;
                            turn_next    = '0;
                            ordered_next = 1'b0;
                        end
                        OP_NEXT:
                        begin
                            if (count_reg == '0)
                            begin
                                res_id_next    = '0;
                                res_run_next   = '0;
                                res_fin_next   = 1'b0;
                                res_empty_next = 1'b1;
                                state_next     = ST_EMIT;
                            end
                            else if (ordered_reg)
                            begin
                                state_next = ST_FETCH;
                            end
                            else if ((mode_reg == SORT_BURST || mode_reg == SORT_PRIO)
                                     && count_reg > CNT_W'(1))
                            begin
                                i_next     = CNT_W'(1);
                                state_next = ST_KEY_RD;
                            end
                            else
                            begin
                                ordered_next = 1'b1;
                                turn_next    = '0;
                                state_next   = ST_FETCH;
                            end
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_KEY_RD:
            begin
                rd_addr    = i_reg[IDX_W-1:0];
                state_next = ST_KEY_LAT;
            end
            ST_KEY_LAT:
            begin
                key_next   = rd_data_reg;
                j_next     = i_reg[IDX_W-1:0];
                rd_addr    = i_reg[IDX_W-1:0] - IDX_W'(1);
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                wr_en   = 1'b1;
                wr_addr = j_reg;
                if (goes_before(mode_reg, key_reg, rd_data_reg))
                begin
                    wr_data = rd_data_reg;
                    j_next  = j_reg - IDX_W'(1);
                    rd_addr = j_reg - IDX_W'(2);
                    if (j_reg == IDX_W'(1))
                    begin
                        state_next = ST_PLACE;
                    end
                end
                else
                begin
                    wr_data = key_reg;
                    i_next  = i_inc;
                    if (i_inc < count_reg)
                    begin
                        state_next = ST_KEY_RD;
                    end
                    else
                    begin
                        ordered_next = 1'b1;
                        turn_next    = '0;
                        state_next   = ST_FETCH;
                    end
                end
            end
            ST_PLACE:
            begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = key_reg;
                i_next  = i_inc;
                if (i_inc < count_reg)
                begin
                    state_next = ST_KEY_RD;
                end
                else
                begin
                    ordered_next = 1'b1;
                    turn_next    = '0;
                    state_next   = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                pos_next   = (CNT_W'(turn_reg) >= count_reg) ? '0 : turn_reg;
                rd_addr    = pos_next;
                state_next = ST_SLICE;
            end
            ST_SLICE:
            begin
                res_id_next    = rd_data_reg.id;
                res_empty_next = 1'b0;
                if (rd_data_reg.remaining <= q_eff)
                begin
                    res_run_next = rd_data_reg.remaining;
                    res_fin_next = 1'b1;
                    i_next       = CNT_W'(pos_reg);
                    state_next   = ST_SHIFT_RD;
                end
                else
                begin
                    wr_en             = 1'b1;
                    wr_addr           = pos_reg;
                    wr_data.remaining = rd_data_reg.remaining - q_eff;
                    res_run_next      = q_eff;
                    res_fin_next      = 1'b0;
                    turn_next         = (pos_inc >= count_reg) ? '0 : pos_inc[IDX_W-1:0];
                    state_next        = ST_EMIT;
                end
            end
            ST_SHIFT_RD:
            begin
                if (i_inc < count_reg)
                begin
                    rd_addr    = i_inc[IDX_W-1:0];
                    state_next = ST_SHIFT_WR;
                end
                else
                begin
                    count_next = count_dec;
                    turn_next  = (CNT_W'(pos_reg) >= count_dec) ? '0 : pos_reg;
                    state_next = ST_EMIT;
                end
            end
            ST_SHIFT_WR:
            begin
                wr_en      = 1'b1;
                wr_addr    = i_reg[IDX_W-1:0];
                wr_data    = rd_data_reg;
                i_next     = i_inc;
                state_next = ST_SHIFT_RD;
            end
            ST_EMIT:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {2'b00, res_fin_reg, res_run_reg, res_id_reg};
                    m_user_next  = res_empty_reg;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we && cfg_addr == CFG_SORT_MODE)
        begin
            ordered_next = 1'b0;
        end
    end

    `SRRS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_TASKS),
        "task count past table size")
    `SRRS_ASSERT_NEXT(a_full_drop,
        s_fire && s_axis_tuser == OP_LOAD && count_reg == CNT_W'(MAX_TASKS),
        count_reg == CNT_W'(MAX_TASKS), "load into full table changed count")
    `SRRS_ASSERT_NEXT(a_clear_empties, s_fire && s_axis_tuser == OP_CLEAR,
        count_reg == '0 && turn_reg == '0, "clear left tasks in table")
    `SRRS_ASSERT_NOW(a_fetch_ordered, state_reg == ST_FETCH, ordered_reg,
        "slice fetched from unordered table")
    `SRRS_ASSERT_NOW(a_empty_zero, m_valid_reg && m_user_reg, m_data_reg == '0,
        "empty result carries nonzero fields")

endmodule

`default_nettype wire

[tb/tb_sorted_round_robin_scheduler.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the sorted round robin scheduler: directed and random streams.
module tb_sorted_round_robin_scheduler
    import srrs_pkg::*;
();

    localparam logic [1:0] OP_RESERVED = 2'd3;
    localparam logic [MODE_W-1:0] SORT_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] SORT_SPARE = 2'd3;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int SETTLE_CYCLES = 40;
    localparam int PHASE_ITEMS = 120;
    localparam int STALL_CYCLES = 400;
    localparam int STALL_AFTER = 330;
    localparam int PHASES = 7;

    localparam logic [MODE_W-1:0] PHASE_MODE [PHASES] = '{
        SORT_BURST, SORT_PRIO, SORT_SPARE, SORT_BURST, SORT_PRIO, SORT_LOAD, SORT_PRIO
    };
    localparam logic [BURST_W-1:0] PHASE_QUANTUM [PHASES] = '{
        16'd0, 16'd65535, 16'd1, 16'd7, 16'd3, 16'd65535, 16'd16
    };

    typedef struct packed {
        logic [ID_W-1:0]    id;
        logic [BURST_W-1:0] run_time;
        logic               finished;
        logic               empty;
    } slice_t;

    class slice_scoreboard;
        logic [ID_W-1:0]    slot_id [MAX_TASKS];
        logic [PRIO_W-1:0]  slot_prio [MAX_TASKS];
        logic [BURST_W-1:0] slot_left [MAX_TASKS];
        int                 live;
        logic [NID_W-1:0]   load_count;
        int                 turn;
        bit                 sorted;
        logic [MODE_W-1:0]  mode;
        logic [BURST_W-1:0] quantum;
        slice_t             expected_slices [$];
        int                 errors;

        function new();
            live = 0;
            load_count = '0;
            turn = 0;
            sorted = 1'b0;
            mode = SORT_LOAD;
            quantum = QUANTUM_RESET;
            errors = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [15:0] value);
            if (idx == CFG_SORT_MODE)
            begin
                mode = value[MODE_W-1:0];
                sorted = 1'b0;
            end
            else
            begin
                quantum = value;
            end
        endfunction

        function bit ranks_before(int a, int b);
            if (mode == SORT_BURST)
            begin
                return slot_left[a] < slot_left[b];
            end
            if (mode == SORT_PRIO)
            begin
                return slot_prio[a] > slot_prio[b];
            end
            return 1'b0;
        endfunction

        // Stable insertion sort of the live slots.
        function void sort_table();
            int                 j;
            logic [ID_W-1:0]    id_tmp;
            logic [PRIO_W-1:0]  prio_tmp;
            logic [BURST_W-1:0] left_tmp;
            for (int i = 1; i < live; i++)
            begin
                j = i;
                while (j > 0 && ranks_before(j, j - 1))
                begin
                    id_tmp = slot_id[j];
                    prio_tmp = slot_prio[j];
                    left_tmp = slot_left[j];
                    slot_id[j] = slot_id[j-1];
                    slot_prio[j] = slot_prio[j-1];
                    slot_left[j] = slot_left[j-1];
                    slot_id[j-1] = id_tmp;
                    slot_prio[j-1] = prio_tmp;
                    slot_left[j-1] = left_tmp;
                    j--;
                end
            end
            turn = 0;
            sorted = 1'b1;
        endfunction

        function void note_input(logic [1:0] op, logic [PRIO_W-1:0] prio,
                                 logic [BURST_W-1:0] burst);
            slice_t             s;
            int                 pos;
            logic [BURST_W-1:0] q;
            case (op)
                OP_LOAD:
                begin
                    if (live < MAX_TASKS)
                    begin
                        slot_id[live] = load_count[ID_W-1:0];
                        slot_prio[live] = prio;
                        slot_left[live] = burst;
                        live++;
                        load_count++;
                        sorted = 1'b0;
                    end
                end
                OP_CLEAR:
                begin
                    live = 0;
                    load_count = '0;
                    turn = 0;
                    sorted = 1'b0;
                end
                OP_NEXT:
                begin
                    s = '0;
                    if (live == 0)
                    begin
                        s.empty = 1'b1;
                    end
                    else
                    begin
                        if (!sorted)
                        begin
                            sort_table();
                        end
                        pos = (turn >= live) ? 0 : turn;
                        q = (quantum == '0) ? BURST_W'(1) : quantum;
                        s.id = slot_id[pos];
                        if (slot_left[pos] <= q)
                        begin
                            s.run_time = slot_left[pos];
                            s.finished = 1'b1;
                            for (int i = pos; i + 1 < live; i++)
                            begin
                                slot_id[i] = slot_id[i+1];
                                slot_prio[i] = slot_prio[i+1];
                                slot_left[i] = slot_left[i+1];
                            end
                            live--;
                        end
                        else
                        begin
                            s.run_time = q;
                            slot_left[pos] = slot_left[pos] - q;
                            pos++;
                        end
                        turn = (pos >= live) ? 0 : pos;
                    end
                    expected_slices = {expected_slices, s};
                end
                default:
                begin
                end
            endcase
        endfunction

        function void check_result(logic [23:0] data, logic empty_flag);
            slice_t want;
            slice_t got;
            got.id = data[4:0];
            got.run_time = data[20:5];
            got.finished = data[21];
            got.empty = empty_flag;
            if (expected_slices.size() == 0)
            begin
                $error("unexpected slice: task_id %0d run_time %0d", got.id, got.run_time);
                errors++;
                return;
            end
            want = expected_slices.pop_front();
            if (got.id !== want.id)
            begin
                $error("task_id: expected %0d, actual %0d", want.id, got.id);
                errors++;
            end
            if (got.run_time !== want.run_time)
            begin
                $error("run_time: expected %0d, actual %0d", want.run_time, got.run_time);
                errors++;
            end
            if (got.finished !== want.finished)
            begin
                $error("task_finished: expected %0d, actual %0d", want.finished, got.finished);
                errors++;
            end
            if (got.empty !== want.empty)
            begin
                $error("schedule_empty: expected %0d, actual %0d", want.empty, got.empty);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;   // task_priority[7:0], task_burst[23:8]
    logic [1:0]  s_axis_tuser;   // opcode[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;   // task_id[4:0], run_time[20:5], task_finished[21]
    logic        m_axis_tuser;   // schedule_empty[0]
    logic        cfg_we;
    logic        cfg_addr;
    logic [15:0] cfg_wdata;

    slice_scoreboard sb;
    int              items_sent = 0;
    int              idle_cycles = 0;

    sorted_round_robin_scheduler i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [PRIO_W-1:0] random_prio();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
        begin
            return 8'd0;
        end
        if (r < 20)
        begin
            return 8'd255;
        end
        if (r < 50)
        begin
            return PRIO_W'($urandom_range(0, 3));
        end
        return PRIO_W'($urandom_range(0, 255));
    endfunction

    function automatic logic [BURST_W-1:0] random_burst();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return BURST_W'($urandom_range(0, 12));
        end
        if (r < 75)
        begin
            return BURST_W'($urandom_range(0, 200));
        end
        if (r < 85)
        begin
            return 16'd0;
        end
        if (r < 92)
        begin
            return 16'd65535;
        end
        return BURST_W'($urandom_range(0, 65535));
    endfunction

    task automatic send_item(logic [1:0] op, logic [PRIO_W-1:0] prio,
                             logic [BURST_W-1:0] burst);
        int r;
        int gap;
        r = $urandom_range(0, 99);
        if (r < 50)
        begin
            gap = 0;
        end
        else if (r < 90)
        begin
            gap = $urandom_range(1, 3);
        end
        else
        begin
            gap = $urandom_range(10, 40);
        end
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {burst, prio};
        s_axis_tuser <= op;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_input(op, prio, burst);
        if (op != OP_RESERVED)
        begin
            items_sent++;
        end
    endtask

    // Drop valid, drain all pending slices, then let trailing loads retire.
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_slices.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] value);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        sb.write_reg(idx, value);
    endtask

    task automatic apply_settings(logic [MODE_W-1:0] mode, logic [BURST_W-1:0] q);
        logic [13:0] pad;
        pad = 14'($urandom);
        write_reg(CFG_SORT_MODE, {pad, mode});
        write_reg(CFG_QUANTUM, q);
        cfg_we <= 1'b0;
    endtask

    task automatic run_sequence();
        int n_loads;
        int n_next;
        int r;
        if ($urandom_range(0, 3) == 0)
        begin
            send_item(OP_CLEAR, random_prio(), random_burst());
        end
        n_loads = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 36) : $urandom_range(1, 6);
        repeat (n_loads) send_item(OP_LOAD, random_prio(), random_burst());
        n_next = $urandom_range(n_loads, 3 * n_loads + 2);
        repeat (n_next)
        begin
            r = $urandom_range(0, 99);
            if (r < 8)
            begin
                send_item(OP_LOAD, random_prio(), random_burst());
            end
            else if (r < 12)
            begin
                send_item(OP_RESERVED, PRIO_W'($urandom), BURST_W'($urandom));
            end
            else if (r < 14)
            begin
                send_item(2'($urandom_range(0, 3)), random_prio(), random_burst());
            end
            else
            begin
                send_item(OP_NEXT, PRIO_W'($urandom), BURST_W'($urandom));
            end
        end
    endtask

    initial
    begin
        int start;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = OP_LOAD;
        cfg_we = 1'b0;
        cfg_addr = CFG_SORT_MODE;
        cfg_wdata = '0;
        sb = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_item(OP_NEXT, 8'd0, 16'd0);
        send_item(OP_RESERVED, 8'hFF, 16'hFFFF);
        send_item(OP_LOAD, 8'd255, 16'd65535);
        send_item(OP_LOAD, 8'd0, 16'd0);
        send_item(OP_LOAD, 8'd128, 16'd5);
        send_item(OP_LOAD, 8'd255, 16'd7);
        repeat (6) send_item(OP_NEXT, 8'd0, 16'd0);
        send_item(OP_LOAD, 8'd7, 16'd3);
        repeat (2) send_item(OP_NEXT, 8'hFF, 16'hFFFF);
        send_item(OP_CLEAR, 8'd0, 16'd0);
        send_item(OP_NEXT, 8'd0, 16'd0);
        send_item(OP_LOAD, 8'd1, 16'd1);
        send_item(OP_NEXT, 8'd0, 16'd0);
        settle();

        for (int p = 0; p < PHASES; p++)
        begin
            apply_settings(PHASE_MODE[p], PHASE_QUANTUM[p]);
            start = items_sent;
            while (items_sent - start < PHASE_ITEMS) run_sequence();
            settle();
        end

        if (sb.errors == 0 && sb.expected_slices.size() == 0)
        begin
            $display("sorted_round_robin_scheduler test passed");
        end
        else
        begin
            $display("sorted_round_robin_scheduler test failed");
        end
        $finish;
    end

    initial
    begin
        int  r;
        bit  held;
        held = 1'b0;
        m_axis_tready = 1'b0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            if (!held && items_sent >= STALL_AFTER)
            begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (STALL_CYCLES) @(posedge clk);
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 45)
                begin
                    m_axis_tready <= 1'b1;
                    repeat ($urandom_range(1, 30)) @(posedge clk);
                end
                else if (r < 93)
                begin
                    m_axis_tready <= 1'b0;
                    repeat ($urandom_range(1, 3)) @(posedge clk);
                end
                else
                begin
                    m_axis_tready <= 1'b0;
                    repeat ($urandom_range(10, 60)) @(posedge clk);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_result(m_axis_tdata, m_axis_tuser);
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles = idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("sorted_round_robin_scheduler test failed");
                $finish;
            end
        end
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/srrs_pkg.sv
rtl/core/sorted_round_robin_scheduler.sv
tb/tb_sorted_round_robin_scheduler.sv
